### src/l2so_pkg.sv
// ----------------------------------------------------------------------------
// l2so_pkg: shared types and constants
// Register map and field widths for the linear to strided offset block.
// ----------------------------------------------------------------------------
package l2so_pkg;

    localparam int unsigned CountW  = 16;
    localparam int unsigned StepW   = 32;
    localparam int unsigned LinW    = 32;
    localparam int unsigned CmpW    = 2;
    localparam int unsigned OffsetW = 35;
    localparam int unsigned AddrW   = 5;
    localparam int unsigned DataW   = 32;

    // Register indexes (byte address divided by four)
    typedef enum logic [2:0] {
        REG_COLUMN_COUNT   = 3'd0,
        REG_ROW_COUNT      = 3'd1,
        REG_FRAME_COUNT    = 3'd2,
        REG_COMPONENT_STEP = 3'd3,
        REG_COLUMN_STEP    = 3'd4,
        REG_ROW_STEP       = 3'd5,
        REG_FRAME_STEP     = 3'd6,
        REG_SEQUENCE_STEP  = 3'd7
    } reg_index_t;

    // Pipeline control, shared by every stage
    typedef struct packed {
        logic en;
    } pipe_ctrl_t;

endpackage

### src/l2so_div_cell.sv
// ----------------------------------------------------------------------------
// l2so_div_cell: one restoring division step
// Brings one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit into the word.
// ----------------------------------------------------------------------------
module l2so_div_cell
    import l2so_pkg::*;
#(
    parameter int unsigned SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pipe_ctrl_t          ctrl,
    input  logic [CountW-1:0]   divisor,
    input  logic                valid_in,
    input  logic [CountW-1:0]   rem_in,
    input  logic [LinW-1:0]     word_in,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                valid_out,
    output logic [CountW-1:0]   rem_out,
    output logic [LinW-1:0]     word_out,
    output logic [SIDE_W-1:0]   side_out
);

    logic [CountW:0]   trial;
    logic [CountW:0]   diff;
    logic              fits;
    logic              valid_reg;
    logic [CountW-1:0] rem_reg;
    logic [CountW-1:0] rem_next;
    logic [LinW-1:0]   word_reg;
    logic [LinW-1:0]   word_next;
    logic [SIDE_W-1:0] side_reg;

    // Trial subtract
    always_comb
    begin
        trial     = {rem_in, word_in[LinW-1]};
        diff      = trial - {1'b0, divisor};
        fits      = (trial >= {1'b0, divisor});
        rem_next  = fits ? diff[CountW-1:0] : trial[CountW-1:0];
        word_next = {word_in[LinW-2:0], fits};
    end

    // Hold valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.en)
        begin
            valid_reg <= valid_in;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            rem_reg  <= rem_next;
            word_reg <= word_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign word_out  = word_reg;
    assign side_out  = side_reg;

endmodule

### src/l2so_divider.sv
// ----------------------------------------------------------------------------
// l2so_divider: bit-serial pipelined divider
// A chain of one cell per dividend bit; a request enters every cycle while ctrl.en is high.
// ----------------------------------------------------------------------------
module l2so_divider
    import l2so_pkg::*;
#(
    parameter int unsigned SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pipe_ctrl_t          ctrl,
    input  logic [CountW-1:0]   divisor,
    input  logic                valid_in,
    input  logic [LinW-1:0]     dividend,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                valid_out,
    output logic [LinW-1:0]     quotient,
    output logic [CountW-1:0]   remainder,
    output logic [SIDE_W-1:0]   side_out
);

    logic              v   [LinW+1];
    logic [CountW-1:0] r   [LinW+1];
    logic [LinW-1:0]   w   [LinW+1];
    logic [SIDE_W-1:0] s   [LinW+1];

    assign v[0] = valid_in;
    assign r[0] = '0;
    assign w[0] = dividend;
    assign s[0] = side_in;

    // One cell per quotient bit
    for (genvar i = 0; i < LinW; i++)
    begin : g_cell
        l2so_div_cell #(.SIDE_W(SIDE_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .divisor   (divisor),
            .valid_in  (v[i]),
            .rem_in    (r[i]),
            .word_in   (w[i]),
            .side_in   (s[i]),
            .valid_out (v[i+1]),
            .rem_out   (r[i+1]),
            .word_out  (w[i+1]),
            .side_out  (s[i+1])
        );
    end

    assign valid_out = v[LinW];
    assign quotient  = w[LinW];
    assign remainder = r[LinW];
    assign side_out  = s[LinW];

endmodule

### src/l2so_dot.sv
// ----------------------------------------------------------------------------
// l2so_dot: strided dot product and output register
// Multiplies each index by its step, then sums modulo 2^32 and scales by
// the element size into the result register.
// ----------------------------------------------------------------------------
module l2so_dot
    import l2so_pkg::*;
#(
    parameter int unsigned ELEM_BYTES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pipe_ctrl_t          ctrl,
    input  logic [StepW-1:0]    component_step,
    input  logic [StepW-1:0]    column_step,
    input  logic [StepW-1:0]    row_step,
    input  logic [StepW-1:0]    frame_step,
    input  logic [StepW-1:0]    sequence_step,
    input  logic                valid_in,
    input  logic [CmpW-1:0]     cmp_in,
    input  logic [CountW-1:0]   col_in,
    input  logic [CountW-1:0]   row_in,
    input  logic [CountW-1:0]   frm_in,
    input  logic [LinW-1:0]     seq_in,
    output logic                valid_out,
    output logic [CmpW-1:0]     cmp_out,
    output logic [CountW-1:0]   col_out,
    output logic [CountW-1:0]   row_out,
    output logic [CountW-1:0]   frm_out,
    output logic [LinW-1:0]     seq_out,
    output logic [OffsetW-1:0]  offset_out
);

    logic                mul_valid_reg;
    logic [StepW-1:0]    prod_reg [5];
    logic [CmpW-1:0]     mcmp_reg;
    logic [CountW-1:0]   mcol_reg;
    logic [CountW-1:0]   mrow_reg;
    logic [CountW-1:0]   mfrm_reg;
    logic [LinW-1:0]     mseq_reg;
    logic [StepW-1:0]    sum;
    logic [OffsetW-1:0]  offset_next;
    logic                out_valid_reg;
    logic [CmpW-1:0]     cmp_reg;
    logic [CountW-1:0]   col_reg;
    logic [CountW-1:0]   row_reg;
    logic [CountW-1:0]   frm_reg;
    logic [LinW-1:0]     seq_reg;
    logic [OffsetW-1:0]  offset_reg;

    // Sum products and scale by element size
    always_comb
    begin
        sum = prod_reg[0] + prod_reg[1] + prod_reg[2] + prod_reg[3] + prod_reg[4];
        offset_next = OffsetW'(sum) * OffsetW'(ELEM_BYTES);
    end

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.en)
        begin
            mul_valid_reg <= valid_in;
            out_valid_reg <= mul_valid_reg;
        end
    end

    // Advance products and result
    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            prod_reg[0] <= StepW'(cmp_in) * component_step;
            prod_reg[1] <= StepW'(col_in) * column_step;
            prod_reg[2] <= StepW'(row_in) * row_step;
            prod_reg[3] <= StepW'(frm_in) * frame_step;
            prod_reg[4] <= seq_in * sequence_step;
            mcmp_reg    <= cmp_in;
            mcol_reg    <= col_in;
            mrow_reg    <= row_in;
            mfrm_reg    <= frm_in;
            mseq_reg    <= seq_in;
            cmp_reg     <= mcmp_reg;
            col_reg     <= mcol_reg;
            row_reg     <= mrow_reg;
            frm_reg     <= mfrm_reg;
            seq_reg     <= mseq_reg;
            offset_reg  <= offset_next;
        end
    end

    assign valid_out  = out_valid_reg;
    assign cmp_out    = cmp_reg;
    assign col_out    = col_reg;
    assign row_out    = row_reg;
    assign frm_out    = frm_reg;
    assign seq_out    = seq_reg;
    assign offset_out = offset_reg;

endmodule

### src/linear_to_strided_offset.sv
// ----------------------------------------------------------------------------
// linear_to_strided_offset: strided address from a linear element number
// Splits a linear index into five dimension indices and forms the byte
// offset of the element in a strided object.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on linear_valid / linear_stall carrying linear_index;
//   results leave on result_valid / result_stall with the four indices,
//   the sequence quotient and byte_offset (no base address added).
//   Dimension counts and steps are set over the APB port; the user must
//   set them only while idle, which the block itself does not enforce.
//   Each request passes a registered component stage (shift or reciprocal
//   multiply by the fixed component count), then three 32-cell division
//   chains (column, row, frame), one dividend bit per cell, then a
//   multiply stage and a sum/scale stage. A new request is taken every
//   cycle while linear_stall is low; throughput is one per cycle.
//   The whole pipeline advances together; when result_stall holds a
//   waiting result, the pipeline freezes and linear_stall is raised.
//   Reset clears all valid bits, sets the counts to 1 and steps to 0.
//   A count written as 0 acts as 1.
// ----------------------------------------------------------------------------
module linear_to_strided_offset
    import l2so_pkg::*;
#(
    parameter int unsigned COMPONENTS = 1,
    parameter int unsigned ELEM_BYTES = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrW-1:0]    paddr,
    input  logic [DataW-1:0]    pwdata,
    output logic [DataW-1:0]    prdata,
    output logic                pready,
    input  logic                linear_valid,
    output logic                linear_stall,
    input  logic [LinW-1:0]     linear_index,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [CmpW-1:0]     component_index,
    output logic [CountW-1:0]   column_index,
    output logic [CountW-1:0]   row_index,
    output logic [CountW-1:0]   frame_index,
    output logic [LinW-1:0]     sequence_index,
    output logic [OffsetW-1:0]  byte_offset
);

    // Quotient by the component count: exact reciprocal for three, shift otherwise
    localparam logic [LinW-1:0] CmpMul   = (COMPONENTS == 3) ? LinW'(32'hAAAAAAAB) : LinW'(1);
    localparam int unsigned     CmpShift = (COMPONENTS == 3) ? 33 :
                                           (COMPONENTS == 4) ? 2 :
                                           (COMPONENTS == 2) ? 1 : 0;

    logic [CountW-1:0] column_count_reg;
    logic [CountW-1:0] row_count_reg;
    logic [CountW-1:0] frame_count_reg;
    logic [StepW-1:0]  component_step_reg;
    logic [StepW-1:0]  column_step_reg;
    logic [StepW-1:0]  row_step_reg;
    logic [StepW-1:0]  frame_step_reg;
    logic [StepW-1:0]  sequence_step_reg;
    logic [CountW-1:0] col_div;
    logic [CountW-1:0] row_div;
    logic [CountW-1:0] frm_div;
    reg_index_t        reg_sel;
    logic              wr_en;
    pipe_ctrl_t        ctrl;

    logic [2*LinW-1:0] cmp_prod;
    logic [LinW-1:0]   cmp_quot_next;
    logic [LinW-1:0]   cmp_back;
    logic [LinW-1:0]   cmp_diff;
    logic [CmpW-1:0]   cmp_rem_next;
    logic              cmp_valid_reg;
    logic [LinW-1:0]   cmp_quot_reg;
    logic [CmpW-1:0]   cmp_rem_reg;

    logic              v1, v2, v3;
    logic [LinW-1:0]   q1, q2, q3;
    logic [CountW-1:0] r1, r2, r3;
    logic [CmpW-1:0]   s1;
    logic [CmpW+CountW-1:0]   s2;
    logic [CmpW+2*CountW-1:0] s3;

    // Register access
    assign reg_sel = reg_index_t'(paddr[AddrW-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg   <= CountW'(1);
            row_count_reg      <= CountW'(1);
            frame_count_reg    <= CountW'(1);
            component_step_reg <= '0;
            column_step_reg    <= '0;
            row_step_reg       <= '0;
            frame_step_reg     <= '0;
            sequence_step_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_COLUMN_COUNT:   column_count_reg   <= pwdata[CountW-1:0];
                REG_ROW_COUNT:      row_count_reg      <= pwdata[CountW-1:0];
                REG_FRAME_COUNT:    frame_count_reg    <= pwdata[CountW-1:0];
                REG_COMPONENT_STEP: component_step_reg <= pwdata;
                REG_COLUMN_STEP:    column_step_reg    <= pwdata;
                REG_ROW_STEP:       row_step_reg       <= pwdata;
                REG_FRAME_STEP:     frame_step_reg     <= pwdata;
                REG_SEQUENCE_STEP:  sequence_step_reg  <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_COLUMN_COUNT:   prdata = DataW'(column_count_reg);
            REG_ROW_COUNT:      prdata = DataW'(row_count_reg);
            REG_FRAME_COUNT:    prdata = DataW'(frame_count_reg);
            REG_COMPONENT_STEP: prdata = component_step_reg;
            REG_COLUMN_STEP:    prdata = column_step_reg;
            REG_ROW_STEP:       prdata = row_step_reg;
            REG_FRAME_STEP:     prdata = frame_step_reg;
            REG_SEQUENCE_STEP:  prdata = sequence_step_reg;
            default:            prdata = '0;
        endcase
    end

    // Treat a zero count as one
    assign col_div = (column_count_reg == '0) ? CountW'(1) : column_count_reg;
    assign row_div = (row_count_reg == '0) ? CountW'(1) : row_count_reg;
    assign frm_div = (frame_count_reg == '0) ? CountW'(1) : frame_count_reg;

    // Freeze the pipeline while a result waits on a stalled receiver
    assign ctrl.en      = !(result_valid && result_stall);
    assign linear_stall = !ctrl.en;

    // Component digit: quotient and remainder by the fixed component count
    always_comb
    begin
        cmp_prod      = {{LinW{1'b0}}, linear_index} * {{LinW{1'b0}}, CmpMul};
        cmp_quot_next = LinW'(cmp_prod >> CmpShift);
        cmp_back      = cmp_quot_next * LinW'(COMPONENTS);
        cmp_diff      = linear_index - cmp_back;
        cmp_rem_next  = cmp_diff[CmpW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_valid_reg <= 1'b0;
        end
        else if (ctrl.en)
        begin
            cmp_valid_reg <= linear_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            cmp_quot_reg <= cmp_quot_next;
            cmp_rem_reg  <= cmp_rem_next;
        end
    end

    // Column digit
    l2so_divider #(.SIDE_W(CmpW)) u_div_col (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .divisor(col_div),
        .valid_in(cmp_valid_reg), .dividend(cmp_quot_reg), .side_in(cmp_rem_reg),
        .valid_out(v1), .quotient(q1), .remainder(r1), .side_out(s1)
    );

    // Row digit
    l2so_divider #(.SIDE_W(CmpW+CountW)) u_div_row (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .divisor(row_div),
        .valid_in(v1), .dividend(q1), .side_in({s1, r1}),
        .valid_out(v2), .quotient(q2), .remainder(r2), .side_out(s2)
    );

    // Frame digit and sequence quotient
    l2so_divider #(.SIDE_W(CmpW+2*CountW)) u_div_frm (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .divisor(frm_div),
        .valid_in(v2), .dividend(q2), .side_in({s2, r2}),
        .valid_out(v3), .quotient(q3), .remainder(r3), .side_out(s3)
    );

    // Dot product and result register
    l2so_dot #(.ELEM_BYTES(ELEM_BYTES)) u_dot (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .component_step (component_step_reg),
        .column_step    (column_step_reg),
        .row_step       (row_step_reg),
        .frame_step     (frame_step_reg),
        .sequence_step  (sequence_step_reg),
        .valid_in       (v3),
        .cmp_in         (s3[CmpW+2*CountW-1:2*CountW]),
        .col_in         (s3[2*CountW-1:CountW]),
        .row_in         (s3[CountW-1:0]),
        .frm_in         (r3),
        .seq_in         (q3),
        .valid_out      (result_valid),
        .cmp_out        (component_index),
        .col_out        (column_index),
        .row_out        (row_index),
        .frm_out        (frame_index),
        .seq_out        (sequence_index),
        .offset_out     (byte_offset)
    );

endmodule

### sim/tb_linear_to_strided_offset.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_to_strided_offset: self-checking bench for the offset generator
// Programs dimension counts and steps over APB in several phases, streams
// directed and random linear indices with random gaps and output stalls,
// and compares every result against an in-bench mixed-radix predictor.
// ----------------------------------------------------------------------------
module tb_linear_to_strided_offset;
    import l2so_pkg::*;

    localparam int unsigned COMPONENTS = 1;
    localparam int unsigned ELEM_BYTES = 4;
    localparam int unsigned LATENCY    = 99;
    localparam longint      CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [CmpW-1:0]    cmp;
        logic [CountW-1:0]  col;
        logic [CountW-1:0]  row;
        logic [CountW-1:0]  frm;
        logic [LinW-1:0]    seq;
        logic [OffsetW-1:0] off;
    } offset_result_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [AddrW-1:0]   paddr;
    logic [DataW-1:0]   pwdata;
    logic [DataW-1:0]   prdata;
    logic               pready;
    logic               linear_valid;
    logic               linear_stall;
    logic [LinW-1:0]    linear_index;
    logic               result_valid;
    logic               result_stall;
    logic [CmpW-1:0]    component_index;
    logic [CountW-1:0]  column_index;
    logic [CountW-1:0]  row_index;
    logic [CountW-1:0]  frame_index;
    logic [LinW-1:0]    sequence_index;
    logic [OffsetW-1:0] byte_offset;

    // Shadow copy of the register file
    logic [CountW-1:0] cnt_col, cnt_row, cnt_frm;
    logic [StepW-1:0]  stp_cmp, stp_col, stp_row, stp_frm, stp_seq;

    logic [LinW-1:0]  pending_index_q[$];
    offset_result_t   expected_offsets_q[$];
    int               mismatch_count;
    longint           cycle_count;
    int               drive_gap;
    int               stall_gap;

    linear_to_strided_offset #(
        .COMPONENTS(COMPONENTS),
        .ELEM_BYTES(ELEM_BYTES)
    ) u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .linear_valid(linear_valid), .linear_stall(linear_stall),
        .linear_index(linear_index),
        .result_valid(result_valid), .result_stall(result_stall),
        .component_index(component_index), .column_index(column_index),
        .row_index(row_index), .frame_index(frame_index),
        .sequence_index(sequence_index), .byte_offset(byte_offset)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] nonzero(input logic [CountW-1:0] c);
        return (c == '0) ? 64'd1 : {48'd0, c};
    endfunction

    // Split the linear index by mixed radix and form the strided offset
    function automatic offset_result_t split_and_offset(input logic [LinW-1:0] lin);
        offset_result_t r;
        logic [63:0] p1, p2, p3, p4, rem, seq, frm, row, col;
        logic [31:0] eoff;
        logic [63:0] wide;
        p1 = COMPONENTS;
        p2 = p1 * nonzero(cnt_col);
        p3 = p2 * nonzero(cnt_row);
        p4 = p3 * nonzero(cnt_frm);
        rem = {32'd0, lin};
        seq = rem / p4;  rem = rem - seq * p4;
        frm = rem / p3;  rem = rem - frm * p3;
        row = rem / p2;  rem = rem - row * p2;
        col = rem / p1;  rem = rem - col * p1;
        eoff = rem[31:0] * stp_cmp + col[31:0] * stp_col + row[31:0] * stp_row
             + frm[31:0] * stp_frm + seq[31:0] * stp_seq;
        wide = {32'd0, eoff} * ELEM_BYTES;
        r.cmp = rem[CmpW-1:0];
        r.col = col[CountW-1:0];
        r.row = row[CountW-1:0];
        r.frm = frm[CountW-1:0];
        r.seq = seq[LinW-1:0];
        r.off = wide[OffsetW-1:0];
        return r;
    endfunction

    task automatic apb_write(input reg_index_t idx, input logic [DataW-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COLUMN_COUNT:   cnt_col = val[CountW-1:0];
            REG_ROW_COUNT:      cnt_row = val[CountW-1:0];
            REG_FRAME_COUNT:    cnt_frm = val[CountW-1:0];
            REG_COMPONENT_STEP: stp_cmp = val;
            REG_COLUMN_STEP:    stp_col = val;
            REG_ROW_STEP:       stp_row = val;
            REG_FRAME_STEP:     stp_frm = val;
            default:            stp_seq = val;
        endcase
    endtask

    task automatic program_all(input logic [DataW-1:0] c0, c1, c2,
                               input logic [DataW-1:0] s0, s1, s2, s3, s4);
        apb_write(REG_COLUMN_COUNT, c0);
        apb_write(REG_ROW_COUNT, c1);
        apb_write(REG_FRAME_COUNT, c2);
        apb_write(REG_COMPONENT_STEP, s0);
        apb_write(REG_COLUMN_STEP, s1);
        apb_write(REG_ROW_STEP, s2);
        apb_write(REG_FRAME_STEP, s3);
        apb_write(REG_SEQUENCE_STEP, s4);
    endtask

    // Wait until the pipeline has drained
    task automatic drain;
        while (pending_index_q.size() != 0 || linear_valid)
            @(posedge clk);
        while (expected_offsets_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // Pick an index that lands near the object's edges or anywhere
    function automatic logic [LinW-1:0] pick_index;
        logic [63:0] span;
        span = nonzero(cnt_col) * nonzero(cnt_row) * nonzero(cnt_frm) * COMPONENTS;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return (span > 64'hFFFFFFFF) ? $urandom : span[31:0] * $urandom_range(0, 3)
                      + $urandom_range(0, 2) - 1;
            2: return $urandom_range(0, 255);
            default: return 32'hFFFFFFFF - $urandom_range(0, 255);
        endcase
    endfunction

    task automatic queue_random(input int n);
        repeat (n) pending_index_q.push_back(pick_index());
    endtask

    // Driver: present one request per queued index after a random gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_valid <= 1'b0;
            linear_index <= '0;
            drive_gap    <= 0;
        end
        else if (linear_valid && !linear_stall)
        begin
            expected_offsets_q.push_back(split_and_offset(linear_index));
            if (drive_gap == 0 && pending_index_q.size() != 0)
            begin
                linear_index <= pending_index_q.pop_front();
                drive_gap    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            end
            else
                linear_valid <= 1'b0;
        end
        else if (!linear_valid)
        begin
            if (drive_gap != 0)
                drive_gap <= drive_gap - 1;
            else if (pending_index_q.size() != 0)
            begin
                linear_valid <= 1'b1;
                linear_index <= pending_index_q.pop_front();
                drive_gap    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            end
        end
    end

    // Monitor: compare each accepted result and redraw the output stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_gap    <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_offsets_q.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("unexpected result offset=%h", byte_offset);
                end
                else
                begin
                    offset_result_t want;
                    want = expected_offsets_q.pop_front();
                    if (want.cmp !== component_index || want.col !== column_index ||
                        want.row !== row_index || want.frm !== frame_index ||
                        want.seq !== sequence_index || want.off !== byte_offset)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("mismatch exp %h %h %h %h %h %h got %h %h %h %h %h %h",
                                want.cmp, want.col, want.row, want.frm, want.seq, want.off,
                                component_index, column_index, row_index, frame_index,
                                sequence_index, byte_offset);
                    end
                end
                stall_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            end
            // Hold the stall while the drawn gap counts down
            if (stall_gap != 0)
            begin
                result_stall <= 1'b1;
                if (!(result_valid && !result_stall))
                    stall_gap <= stall_gap - 1;
            end
            else if (!(result_valid && !result_stall))
                result_stall <= 1'b0;
            else
                result_stall <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        mismatch_count = 0;
        cycle_count    = 0;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        cnt_col = 1; cnt_row = 1; cnt_frm = 1;
        stp_cmp = 0; stp_col = 0; stp_row = 0; stp_frm = 0; stp_seq = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: extremes of the index under unit counts
        pending_index_q.push_back(32'd0);
        pending_index_q.push_back(32'hFFFFFFFF);
        pending_index_q.push_back(32'h5555AAAA);
        drain();

        // Small counts, small steps; zero count acts as one
        program_all(3, 0, 5, 32'd7, 32'd1, 32'd3, 32'd11, 32'd100);
        for (int i = 0; i < 12; i++)
            pending_index_q.push_back(i);
        pending_index_q.push_back(32'hFFFFFFFF);
        pending_index_q.push_back(32'h80000000);
        pending_index_q.push_back(32'h7FFFFFFF);
        drain();

        // Largest counts, largest steps; wide products exceed the index
        program_all(32'hFFFFFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        pending_index_q.push_back(32'd0);
        pending_index_q.push_back(32'd65534);
        pending_index_q.push_back(32'd65535);
        pending_index_q.push_back(32'hFFFFFFFF);
        pending_index_q.push_back(32'hFFFEFFFF);
        queue_random(100);
        drain();

        // Random settings
        repeat (5)
        begin
            program_all($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20),
                        $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20),
                        $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20),
                        $urandom, $urandom, $urandom, $urandom, $urandom);
            queue_random(100);
            drain();
        end

        if (mismatch_count == 0 && expected_offsets_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
